// ----- hw/rtl/fhm_pkg.sv -----
// Shared types, constants and the carrier table generator for the hop mixer.
`default_nettype none

package fhm_pkg;

   // Configuration port shape and register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PULSE_LENGTH   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PULSES_PER_HOP = 2'd1;

   // Register limits
   localparam int PULSE_LENGTH_BITS   = 13;
   localparam int PULSES_PER_HOP_BITS = 9;
   localparam int PULSE_LENGTH_MAX    = 4096;
   localparam int PULSES_PER_HOP_MAX  = 256;
   localparam int POSITION_BITS       = 20;
   localparam int HOP_SIZE_BITS       = 21;

   // Fixed step format on the input side
   localparam int STEP_BITS = 32;

   // Carrier format, Q1.15
   localparam int CARRIER_BITS = 16;
   localparam int CARRIER_FRAC = 15;
   localparam int ROUND_HALF   = 1 << (CARRIER_FRAC - 1);

   // Queue between front and back
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = 2;
   localparam int QUEUE_CNT_BITS  = 3;

   // Pi/2 in Q30
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } quadrant_type;

   // Quarter-wave sine entry k of a table with 2^addr_bits steps per quadrant,
   // Q30 Taylor series rounded to Q15 and clipped; evaluated at elaboration.
   function automatic logic [CARRIER_BITS-1:0] quarter_sine(input int unsigned k,
                                                            input int unsigned addr_bits);
      longint x;
      longint term;
      longint sum;
      begin
         x    = (HALF_PI_Q30 * longint'(k)) >>> addr_bits;
         term = x;
         sum  = x;
         for (int n = 1; n <= 7; n++) begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            case (n)
               1:       term = term / 6;
               2:       term = term / 20;
               3:       term = term / 42;
               4:       term = term / 72;
               5:       term = term / 110;
               6:       term = term / 156;
               default: term = term / 210;
            endcase
            if ((n % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         sum = (sum + 16384) >>> 15;
         if (sum > 32767) begin
            sum = 32767;
         end
         return sum[CARRIER_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fhm_front.sv -----
// Front end: configuration registers, hop group tracking and phase accumulation.
`default_nettype none

module fhm_front
   import fhm_pkg::*;
#(
   parameter int PHASE_BITS  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]           csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]            csr_wdata,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]       sample_i,
   input  wire logic signed [SAMPLE_BITS-1:0]       sample_q,
   input  wire logic [STEP_BITS-1:0]                hop_phase_step,
   input  wire logic                                q_full,
   output logic                                     q_push,
   output logic [PHASE_BITS+2*SAMPLE_BITS:0]        q_data
);

   logic [PULSE_LENGTH_BITS-1:0]   pulse_length_ff, pulse_length_in;
   logic [PULSES_PER_HOP_BITS-1:0] pulses_per_hop_ff, pulses_per_hop_in;
   logic [PULSE_LENGTH_BITS-1:0]   pl_eff;
   logic [PULSES_PER_HOP_BITS-1:0] ph_eff;
   logic [HOP_SIZE_BITS-1:0]       hop_size_ff, hop_size_in;
   logic [POSITION_BITS-1:0]       position_ff, position_in;
   logic [HOP_SIZE_BITS-1:0]       position_inc;
   logic [PHASE_BITS-1:0]          phase_ff, phase_in;
   logic [PHASE_BITS-1:0]          step_ff, step_in;
   logic [PHASE_BITS+STEP_BITS-1:0] step_wide;
   logic [PHASE_BITS-1:0]          step_scaled;
   logic [PHASE_BITS-1:0]          phase_next;
   logic                           start;
   logic                           accept;

   // Decode configuration writes; unknown indexes are dropped
   always_comb begin
      pulse_length_in   = pulse_length_ff;
      pulses_per_hop_in = pulses_per_hop_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PULSE_LENGTH:   pulse_length_in   = csr_wdata[PULSE_LENGTH_BITS-1:0];
            REG_PULSES_PER_HOP: pulses_per_hop_in = csr_wdata[PULSES_PER_HOP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp the register values being loaded: zero counts as one, oversize as the maximum,
   // so the group size register changes on the same edge as the registers
   always_comb begin
      if (pulse_length_in == '0) begin
         pl_eff = PULSE_LENGTH_BITS'(1);
      end else if (pulse_length_in > PULSE_LENGTH_BITS'(PULSE_LENGTH_MAX)) begin
         pl_eff = PULSE_LENGTH_BITS'(PULSE_LENGTH_MAX);
      end else begin
         pl_eff = pulse_length_in;
      end
      if (pulses_per_hop_in == '0) begin
         ph_eff = PULSES_PER_HOP_BITS'(1);
      end else if (pulses_per_hop_in > PULSES_PER_HOP_BITS'(PULSES_PER_HOP_MAX)) begin
         ph_eff = PULSES_PER_HOP_BITS'(PULSES_PER_HOP_MAX);
      end else begin
         ph_eff = pulses_per_hop_in;
      end
   end

   assign hop_size_in = HOP_SIZE_BITS'(pl_eff) * HOP_SIZE_BITS'(ph_eff);

   // Scale the 2^-32 turn step to the accumulator width
   assign step_wide   = {hop_phase_step, PHASE_BITS'(0)};
   assign step_scaled = step_wide[PHASE_BITS+STEP_BITS-1:STEP_BITS];

   assign start      = (position_ff == '0);
   assign phase_next = start ? step_scaled : (phase_ff + step_ff);
   assign in_ready   = !q_full;
   assign accept     = in_valid && !q_full;

   // Advance group position and phase on each accepted transaction
   assign position_inc = HOP_SIZE_BITS'(position_ff) + HOP_SIZE_BITS'(1);
   always_comb begin
      position_in = position_ff;
      phase_in    = phase_ff;
      step_in     = step_ff;
      if (accept) begin
         phase_in = phase_next;
         if (start) begin
            step_in = step_scaled;
         end
         if (position_inc >= hop_size_ff) begin
            position_in = '0;
         end else begin
            position_in = position_inc[POSITION_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_length_ff   <= PULSE_LENGTH_BITS'(1);
         pulses_per_hop_ff <= PULSES_PER_HOP_BITS'(1);
         hop_size_ff       <= HOP_SIZE_BITS'(1);
         position_ff       <= '0;
         phase_ff          <= '0;
         step_ff           <= '0;
      end else begin
         pulse_length_ff   <= pulse_length_in;
         pulses_per_hop_ff <= pulses_per_hop_in;
         hop_size_ff       <= hop_size_in;
         position_ff       <= position_in;
         phase_ff          <= phase_in;
         step_ff           <= step_in;
      end
   end

   // Queue entry: sample_i, sample_q, phase, hop start (low bit first)
   assign q_push = accept;
   assign q_data = {start, phase_next, sample_q, sample_i};

endmodule

`default_nettype wire

// ----- hw/rtl/fhm_queue.sv -----
// Short first-in first-out queue between the front end and the mixing pipeline.
`default_nettype none

module fhm_queue
   import fhm_pkg::*;
#(
   parameter int WIDTH = 65
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  full,
   output logic                  empty
);

   logic [WIDTH-1:0]          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full     = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Move pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/fhm_back.sv -----
// Mixing pipeline: table address, carrier lookup, products, round and saturate.
`default_nettype none

module fhm_back
   import fhm_pkg::*;
#(
   parameter int PHASE_BITS    = 32,
   parameter int LUT_ADDR_BITS = 10,
   parameter int SAMPLE_BITS   = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_empty,
   input  wire logic [PHASE_BITS+2*SAMPLE_BITS:0] q_data,
   output logic                                   q_pop,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic signed [SAMPLE_BITS-1:0]          out_i,
   output logic signed [SAMPLE_BITS-1:0]          out_q,
   output logic                                   out_hop_start
);

   localparam int QUARTER_N = 1 << LUT_ADDR_BITS;
   localparam int DSH       = PHASE_BITS - LUT_ADDR_BITS - 2;
   localparam int ADDR_BITS = LUT_ADDR_BITS + 2;
   localparam int ROM_BITS  = LUT_ADDR_BITS + 1;
   localparam int PROD_BITS = SAMPLE_BITS + CARRIER_BITS;
   localparam int SUM_BITS  = SAMPLE_BITS + CARRIER_BITS + 2;
   localparam int RND_BITS  = SUM_BITS - CARRIER_FRAC;
   localparam logic signed [RND_BITS-1:0] SAT_MAX = RND_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [RND_BITS-1:0] SAT_MIN = -SAT_MAX - RND_BITS'(1);

   // Queue entry fields
   logic signed [SAMPLE_BITS-1:0] q_si;
   logic signed [SAMPLE_BITS-1:0] q_sq;
   logic [PHASE_BITS-1:0]         q_phase;
   logic                          q_start;
   logic [ADDR_BITS-1:0]          addr;

   // Stage registers
   logic                          a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic                          ready_a, ready_b, ready_c, ready_d;
   logic [1:0]                    a_quad_ff;
   logic [LUT_ADDR_BITS-1:0]      a_r_ff;
   logic signed [SAMPLE_BITS-1:0] a_si_ff, a_sq_ff, b_si_ff, b_sq_ff;
   logic                          a_start_ff, b_start_ff, c_start_ff;
   logic signed [CARRIER_BITS-1:0] b_sin_ff, b_cos_ff, sin_in, cos_in;
   logic signed [PROD_BITS-1:0]   c_ic_ff, c_qs_ff, c_is_ff, c_qc_ff;
   logic signed [SAMPLE_BITS-1:0] d_i_ff, d_q_ff, d_i_in, d_q_in;
   logic                          d_start_ff;

   logic [ROM_BITS-1:0]           r_ix, m_ix;
   logic signed [CARRIER_BITS-1:0] t_r, t_m;
   logic signed [CARRIER_BITS-1:0] sine_rom [QUARTER_N+1];

   logic signed [SUM_BITS-1:0]    sum_i, sum_q;
   logic signed [RND_BITS-1:0]    rnd_i, rnd_q;

   assign {q_start, q_phase, q_sq, q_si} = q_data;

   // Stall chain: a stage loads when it is empty or its successor moves
   assign ready_d = !d_valid_ff || out_ready;
   assign ready_c = !c_valid_ff || ready_d;
   assign ready_b = !b_valid_ff || ready_c;
   assign ready_a = !a_valid_ff || ready_b;
   assign q_pop   = !q_empty && ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (ready_a) a_valid_ff <= !q_empty;
         if (ready_b) b_valid_ff <= a_valid_ff;
         if (ready_c) c_valid_ff <= b_valid_ff;
         if (ready_d) d_valid_ff <= c_valid_ff;
      end
   end

   // Round the phase to the table address, wrapping within one turn
   generate
      if (DSH > 0) begin : g_round
         logic [PHASE_BITS-1:0] phase_rnd;
         assign phase_rnd = q_phase + (PHASE_BITS'(1) << (DSH - 1));
         assign addr      = phase_rnd[PHASE_BITS-1:DSH];
      end else begin : g_direct
         assign addr = q_phase[ADDR_BITS-1:0];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (ready_a) begin
         a_quad_ff  <= addr[ADDR_BITS-1:LUT_ADDR_BITS];
         a_r_ff     <= addr[LUT_ADDR_BITS-1:0];
         a_si_ff    <= q_si;
         a_sq_ff    <= q_sq;
         a_start_ff <= q_start;
      end
   end

   // Quarter-wave table, built at elaboration
   generate
      for (genvar k = 0; k <= QUARTER_N; k++) begin : g_rom
         assign sine_rom[k] = $signed(quarter_sine(k, LUT_ADDR_BITS));
      end
   endgenerate

   assign r_ix = ROM_BITS'(a_r_ff);
   assign m_ix = ROM_BITS'(QUARTER_N) - r_ix;
   assign t_r  = sine_rom[r_ix];
   assign t_m  = sine_rom[m_ix];

   // Unfold the quadrant into cosine and sine
   always_comb begin
      case (quadrant_type'(a_quad_ff))
         QUAD_FIRST: begin
            sin_in = t_r;
            cos_in = t_m;
         end
         QUAD_SECOND: begin
            sin_in = t_m;
            cos_in = -t_r;
         end
         QUAD_THIRD: begin
            sin_in = -t_r;
            cos_in = -t_m;
         end
         default: begin
            sin_in = -t_m;
            cos_in = t_r;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ready_b) begin
         b_sin_ff   <= sin_in;
         b_cos_ff   <= cos_in;
         b_si_ff    <= a_si_ff;
         b_sq_ff    <= a_sq_ff;
         b_start_ff <= a_start_ff;
      end
   end

   // Four partial products
   always_ff @(posedge clock) begin
      if (ready_c) begin
         c_ic_ff    <= b_si_ff * b_cos_ff;
         c_qs_ff    <= b_sq_ff * b_sin_ff;
         c_is_ff    <= b_si_ff * b_sin_ff;
         c_qc_ff    <= b_sq_ff * b_cos_ff;
         c_start_ff <= b_start_ff;
      end
   end

   // Combine, round half up and saturate
   assign sum_i = SUM_BITS'(c_ic_ff) - SUM_BITS'(c_qs_ff) + SUM_BITS'(ROUND_HALF);
   assign sum_q = SUM_BITS'(c_is_ff) + SUM_BITS'(c_qc_ff) + SUM_BITS'(ROUND_HALF);
   assign rnd_i = $signed(sum_i[SUM_BITS-1:CARRIER_FRAC]);
   assign rnd_q = $signed(sum_q[SUM_BITS-1:CARRIER_FRAC]);

   always_comb begin
      if (rnd_i > SAT_MAX) begin
         d_i_in = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (rnd_i < SAT_MIN) begin
         d_i_in = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         d_i_in = rnd_i[SAMPLE_BITS-1:0];
      end
      if (rnd_q > SAT_MAX) begin
         d_q_in = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (rnd_q < SAT_MIN) begin
         d_q_in = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         d_q_in = rnd_q[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ready_d) begin
         d_i_ff     <= d_i_in;
         d_q_ff     <= d_q_in;
         d_start_ff <= c_start_ff;
      end
   end

   assign out_valid     = d_valid_ff;
   assign out_i         = d_i_ff;
   assign out_q         = d_q_ff;
   assign out_hop_start = d_start_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/frequency_hop_mixer_unit.sv -----
// Top level of the frequency hopping carrier mixer.
//
// Usage:
//   req_*  : one complex sample per transaction plus the phase step of the
//            current hop; the step is taken only at the first sample of a group
//            of pulse_length * pulses_per_hop samples, where the phase restarts.
//   rsp_*  : one mixed sample per request, in order; rsp_tuser flags the first
//            sample of each hop group.
//   csr_*  : write-only registers, index 0 pulse_length, index 1 pulses_per_hop;
//            write only while no transaction is in flight.
// Throughput: one transaction per cycle unless stalled; the front end accumulates
// phase in a single add, the back end is a four-stage pipeline (address, table,
// multiply, round/saturate).
// Stall: when rsp_tready is low the pipeline holds and a four-entry queue
// absorbs requests; req_tready drops only once that queue is full.
// Reset: synchronous; clears the group position and phase, sets both registers
// to one and empties queue and pipeline.
`default_nettype none

module frequency_hop_mixer_unit
   import fhm_pkg::*;
#(
   parameter int PHASE_BITS    = 32,
   parameter int LUT_ADDR_BITS = 10,
   parameter int SAMPLE_BITS   = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   // sample_i, sample_q, hop_phase_step
   input  wire logic [((2*SAMPLE_BITS+STEP_BITS+7)/8)*8-1:0] req_tdata,
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // out_i, out_q
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            rsp_tdata,
   // hop_start
   output logic                                          rsp_tuser,
   input  wire logic                                     csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]                csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]                 csr_wdata
);

   localparam int ENTRY_BITS = PHASE_BITS + 2*SAMPLE_BITS + 1;
   localparam int RSP_BITS   = ((2*SAMPLE_BITS+7)/8)*8;

   logic                          q_push, q_pop, q_full, q_empty;
   logic [ENTRY_BITS-1:0]         q_push_data, q_pop_data;
   logic signed [SAMPLE_BITS-1:0] out_i, out_q;

   fhm_front #(
      .PHASE_BITS  (PHASE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .sample_i       (req_tdata[SAMPLE_BITS-1:0]),
      .sample_q       (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .hop_phase_step (req_tdata[2*SAMPLE_BITS+STEP_BITS-1:2*SAMPLE_BITS]),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_push_data)
   );

   fhm_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   fhm_back #(
      .PHASE_BITS    (PHASE_BITS),
      .LUT_ADDR_BITS (LUT_ADDR_BITS),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (q_pop_data),
      .q_pop         (q_pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_i         (out_i),
      .out_q         (out_q),
      .out_hop_start (rsp_tuser)
   );

   // Pack result, zero padded to whole bytes
   assign rsp_tdata = RSP_BITS'({out_q, out_i});

   // Queue occupancy is consistent
   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue reports full and empty at once");

   // Queue fills only through a push
   a_queue_fill: assert property (@(posedge clock) disable iff (reset)
      $fell(q_empty) |-> $past(q_push))
      else $error("queue became non-empty without a push");

   // Pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

// ----- test/frequency_hop_mixer_checker.sv -----
// Scoreboard for the hop mixer: tracks the registers, predicts each mixed sample and compares.
`default_nettype none

module frequency_hop_mixer_checker
   import fhm_pkg::*;
#(
   parameter int REQ_DATA_BITS = 64,
   parameter int RSP_DATA_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   // sample_i, sample_q, hop_phase_step
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   // out_i, out_q
   input  wire logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // hop_start
   input  wire logic                      rsp_tuser,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                             mismatch_count,
   output int                             pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LUT_ADDR_BITS = 10;
   localparam int QUARTER_STEPS = 1 << LUT_ADDR_BITS;
   localparam int ADDR_SHIFT    = STEP_BITS - LUT_ADDR_BITS - 2;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [15:0] out_i;
      logic [15:0] out_q;
      logic        hop_start;
   } mixed_sample_type;

   mixed_sample_type               mixed_expected_q[$];
   mixed_sample_type               oldest;
   mixed_sample_type               predicted;
   longint                         quarter_wave[0:QUARTER_STEPS];
   logic [PULSE_LENGTH_BITS-1:0]   pulse_length_reg;
   logic [PULSES_PER_HOP_BITS-1:0] pulses_per_hop_reg;
   int unsigned                    group_pos;
   logic [STEP_BITS-1:0]           carrier_phase;
   logic [STEP_BITS-1:0]           hop_step;
   int                             results_seen;
   logic [15:0]                    got_i;
   logic [15:0]                    got_q;

   // Sine of k quarter-table steps: Q30 Taylor series, rounded to Q15, clipped
   function automatic longint sine_entry(input int k);
      longint x;
      longint term;
      longint sum;
      x    = (HALF_PI_Q30 * longint'(k)) / QUARTER_STEPS;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
         term = (term * x) >>> 30;
         term = (term * x) >>> 30;
         term = term / ((2 * n) * (2 * n + 1));
         sum  = (n % 2 == 1) ? sum - term : sum + term;
      end
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      if (sum > 32767) sum = 32767;
      return sum;
   endfunction

   // Round a Q2.30 product back to Q1.15, half up, and saturate
   function automatic logic [15:0] round_to_sample(input longint acc);
      longint r;
      r = (acc + ROUND_HALF) >>> CARRIER_FRAC;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // Advance the hop state by one sample and return the mixed sample it yields
   function automatic mixed_sample_type mix_next_sample(input logic [REQ_DATA_BITS-1:0] data);
      logic signed [15:0] in_i;
      logic signed [15:0] in_q;
      int unsigned        samples_per_pulse;
      int unsigned        pulses;
      int unsigned        hop_size;
      logic [STEP_BITS:0] phase_rounded;
      logic [11:0]        table_addr;
      quadrant_type       quad;
      int                 offset;
      longint             sine_v;
      longint             cosine_v;
      mixed_sample_type   result;
      in_i = data[15:0];
      in_q = data[31:16];

      // clamp the registers into their legal ranges
      samples_per_pulse = (pulse_length_reg == 0) ? 1 :
                          (pulse_length_reg > PULSE_LENGTH_MAX) ? PULSE_LENGTH_MAX :
                          pulse_length_reg;
      pulses    = (pulses_per_hop_reg == 0) ? 1 :
                  (pulses_per_hop_reg > PULSES_PER_HOP_MAX) ? PULSES_PER_HOP_MAX :
                  pulses_per_hop_reg;
      hop_size  = samples_per_pulse * pulses;

      // latch the step and restart the phase at a group start
      result.hop_start = (group_pos == 0);
      if (result.hop_start) begin
         hop_step      = data[32 +: STEP_BITS];
         carrier_phase = '0;
      end
      carrier_phase = carrier_phase + hop_step;

      // round the phase to a table address and unfold the quadrant
      phase_rounded = {1'b0, carrier_phase} + (33'd1 << (ADDR_SHIFT - 1));
      table_addr    = phase_rounded[ADDR_SHIFT +: 12];
      quad          = quadrant_type'(table_addr[11:10]);
      offset        = table_addr[9:0];
      case (quad)
         QUAD_FIRST: begin
            sine_v   = quarter_wave[offset];
            cosine_v = quarter_wave[QUARTER_STEPS - offset];
         end
         QUAD_SECOND: begin
            sine_v   = quarter_wave[QUARTER_STEPS - offset];
            cosine_v = -quarter_wave[offset];
         end
         QUAD_THIRD: begin
            sine_v   = -quarter_wave[offset];
            cosine_v = -quarter_wave[QUARTER_STEPS - offset];
         end
         default: begin
            sine_v   = -quarter_wave[QUARTER_STEPS - offset];
            cosine_v = quarter_wave[offset];
         end
      endcase

      // complex multiply by the carrier
      result.out_i = round_to_sample(longint'(in_i) * cosine_v - longint'(in_q) * sine_v);
      result.out_q = round_to_sample(longint'(in_i) * sine_v + longint'(in_q) * cosine_v);

      group_pos++;
      if (group_pos >= hop_size) group_pos = 0;
      return result;
   endfunction

   initial begin
      for (int k = 0; k <= QUARTER_STEPS; k++) quarter_wave[k] = sine_entry(k);
   end

   // Follow register writes, score results, queue predictions
   always @(posedge clock) begin
      if (reset) begin
         mixed_expected_q.delete();
         pulse_length_reg   = 1;
         pulses_per_hop_reg = 1;
         group_pos          = 0;
         carrier_phase      = '0;
         hop_step           = '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_PULSE_LENGTH:   pulse_length_reg   = csr_wdata[PULSE_LENGTH_BITS-1:0];
               REG_PULSES_PER_HOP: pulses_per_hop_reg = csr_wdata[PULSES_PER_HOP_BITS-1:0];
               default: ;
            endcase
         end

         // compare a result transaction with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got_i = rsp_tdata[15:0];
            got_q = rsp_tdata[31:16];
            if (mixed_expected_q.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("%0t: result %0d with nothing outstanding: i=%0d q=%0d start=%0b",
                           $realtime, results_seen, $signed(got_i), $signed(got_q), rsp_tuser);
               mismatch_count++;
            end else begin
               oldest = mixed_expected_q.pop_front();
               if (got_i !== oldest.out_i || got_q !== oldest.out_q ||
                   rsp_tuser !== oldest.hop_start) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display("%0t: result %0d expected i=%0d q=%0d start=%0b",
                              $realtime, results_seen, $signed(oldest.out_i),
                              $signed(oldest.out_q), oldest.hop_start);
                     $display("%0t: result %0d actual   i=%0d q=%0d start=%0b",
                              $realtime, results_seen, $signed(got_i), $signed(got_q),
                              rsp_tuser);
                  end
                  mismatch_count++;
               end
            end
            results_seen++;
         end

         if (req_tvalid && req_tready) begin
            predicted = mix_next_sample(req_tdata);
            mixed_expected_q.insert(mixed_expected_q.size(), predicted);
         end
      end
      pending_count = mixed_expected_q.size();
   end

endmodule

`default_nettype wire

// ----- test/frequency_hop_mixer_unit_tb.sv -----
// Testbench top for the hop mixer: clock, reset, stimulus, flow control and the verdict.
`default_nettype none

module frequency_hop_mixer_unit_tb
   import fhm_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS   = 16;
   localparam int REQ_DATA_BITS = ((2 * SAMPLE_BITS + STEP_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int PIPE_LATENCY  = 4;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_ITEMS  = 1850;
   localparam int HOLD_OFF_LEN  = 150;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HIGH = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int mismatch_count;
   int pending_count;
   int requests_accepted = 0;
   int settings_used = 0;
   int cycle_count = 0;
   bit tx_gaps_on = 1'b1;
   bit rx_gaps_on = 1'b1;

   frequency_hop_mixer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   frequency_hop_mixer_checker #(
      .REQ_DATA_BITS (REQ_DATA_BITS),
      .RSP_DATA_BITS (RSP_DATA_BITS)
   ) mix_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Mostly back to back, sometimes a short gap, rarely a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Full-range sample with the rails mixed in
   function automatic logic [15:0] pick_sample();
      logic [31:0] raw;
      raw = $urandom();
      case ($urandom_range(0, 11))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return raw[15:0];
      endcase
   endfunction

   // Random hop step: full range, small offsets, half turn, quadrants
   function automatic logic [31:0] pick_step();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 12) return $urandom();
      if (roll < 17) return 32'($urandom_range(0, 2000)) - 32'd1000;
      if (roll == 17) return 32'h8000_0000;
      if (roll == 18) return 32'h7FFF_FFFF;
      return 32'($urandom_range(0, 3)) << 30;
   endfunction

   // Offer one sample and hold it until the block takes it
   task automatic offer_sample(input logic [15:0] in_i, input logic [15:0] in_q,
                               input logic [31:0] step);
      int gap;
      gap = tx_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {step, in_q, in_i};
      do @(posedge clock); while (!req_tready);
      requests_accepted++;
   endtask

   // Drop valid and wait until every prediction has been matched
   task automatic wait_drained();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock) csr_we <= 1'b0;
   endtask

   // Pick a register setting for the next random phase and program it
   task automatic program_random_setting(output int item_count);
      logic [CSR_DATA_BITS-1:0] pulse_size_val;
      logic [CSR_DATA_BITS-1:0] pulses_val;
      item_count = $urandom_range(40, 140);
      case ($urandom_range(0, 9))
         4: begin
            pulse_size_val = 13'($urandom_range(1, 64));
            pulses_val     = 13'($urandom_range(1, 8));
         end
         5: begin
            // zero registers count as one
            pulse_size_val = $urandom_range(0, 1) ? 13'd0 : 13'($urandom_range(1, 5));
            pulses_val     = $urandom_range(0, 1) ? 13'd0 : 13'($urandom_range(1, 4));
         end
         6: begin
            pulse_size_val = 13'($urandom_range(1, 16));
            pulses_val     = 13'd1;
         end
         7: begin
            pulse_size_val = 13'd1;
            pulses_val     = 13'($urandom_range(1, 16));
         end
         8: begin
            // top of the range and above it, a partial group only
            case ($urandom_range(0, 2))
               0:       pulse_size_val = 13'(PULSE_LENGTH_MAX);
               1:       pulse_size_val = 13'h1FFF;
               default: pulse_size_val = 13'($urandom_range(PULSE_LENGTH_MAX + 1, 8191));
            endcase
            case ($urandom_range(0, 3))
               0:       pulses_val = 13'(PULSES_PER_HOP_MAX);
               1:       pulses_val = 13'h01FF;
               2:       pulses_val = 13'h1FFF;
               default: pulses_val = 13'($urandom_range(PULSES_PER_HOP_MAX + 1, 511));
            endcase
            item_count = $urandom_range(20, 40);
         end
         9: begin
            pulse_size_val = 13'($urandom_range(1, 3));
            pulses_val     = 13'($urandom_range(200, PULSES_PER_HOP_MAX));
         end
         default: begin
            pulse_size_val = 13'($urandom_range(1, 6));
            pulses_val     = 13'($urandom_range(1, 4));
         end
      endcase
      if ($urandom_range(0, 1)) begin
         write_register(REG_PULSE_LENGTH, pulse_size_val);
         write_register(REG_PULSES_PER_HOP, pulses_val);
      end else begin
         write_register(REG_PULSES_PER_HOP, pulses_val);
         write_register(REG_PULSE_LENGTH, pulse_size_val);
      end
      if ($urandom_range(0, 3) == 0)
         write_register($urandom_range(0, 1) ? REG_SPARE_LOW : REG_SPARE_HIGH,
                        13'($urandom()));
      settings_used++;
   endtask

   // Result side: random stalls, plus two long hold-offs to fill the block
   initial begin
      int  stall_left;
      bit  first_hold_done;
      bit  second_hold_done;
      stall_left       = 0;
      first_hold_done  = 1'b0;
      second_hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!first_hold_done && requests_accepted >= 400) begin
            stall_left      = HOLD_OFF_LEN;
            first_hold_done = 1'b1;
         end
         if (!second_hold_done && requests_accepted >= 1300) begin
            stall_left       = HOLD_OFF_LEN;
            second_hold_done = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (rx_gaps_on && $urandom_range(0, 99) < 25)
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) :
                                                          $urandom_range(1, 3);
         end
      end
   end

   // Request side and configuration
   initial begin
      int random_sent;
      int item_count;
      random_sent = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // one-sample groups: rails, half and quarter turns, address rounding edges
      offer_sample(16'h0000, 16'h0000, 32'h0000_0000);
      offer_sample(16'h7FFF, 16'h7FFF, 32'h0000_0000);
      offer_sample(16'h8000, 16'h8000, 32'h0000_0000);
      offer_sample(16'h7FFF, 16'h8000, 32'h8000_0000);
      offer_sample(16'h8000, 16'h7FFF, 32'h7FFF_FFFF);
      offer_sample(16'h8000, 16'h8000, 32'h2000_0000);
      offer_sample(16'h7FFF, 16'h7FFF, 32'h2000_0000);
      offer_sample(16'd12345, -16'sd2345, 32'h4000_0000);
      offer_sample(16'hFFFF, 16'h0001, 32'hC000_0000);
      offer_sample(16'd1000, -16'sd1000, 32'hFFFF_FFFF);
      offer_sample(16'h7FFF, 16'h0000, 32'h0000_0001);
      offer_sample(16'h0000, 16'h8000, 32'h0008_0000);
      offer_sample(16'h8000, 16'h0000, 32'h3FF8_0000);
      offer_sample(16'd5, 16'd5, 32'hFFF8_0000);

      // six-sample groups; later steps in a group must be ignored
      wait_drained();
      write_register(REG_PULSE_LENGTH, 13'd3);
      write_register(REG_PULSES_PER_HOP, 13'd2);
      offer_sample(16'd20000, -16'sd7000, 32'h0123_4567);
      offer_sample(-16'sd15000, 16'd9000, 32'hDEAD_BEEF);
      offer_sample(16'd300, 16'd32000, 32'h0000_0000);
      offer_sample(-16'sd32768, 16'd1, 32'h8000_0000);

      // shrink the group below the current position
      wait_drained();
      write_register(REG_PULSE_LENGTH, 13'd1);
      repeat (4) offer_sample(pick_sample(), pick_sample(), pick_step());

      // zero registers, then values above range, then writes to unused indexes
      wait_drained();
      write_register(REG_PULSE_LENGTH, 13'd0);
      write_register(REG_PULSES_PER_HOP, 13'd0);
      repeat (2) offer_sample(pick_sample(), pick_sample(), pick_step());
      wait_drained();
      write_register(REG_PULSE_LENGTH, 13'h1FFF);
      write_register(REG_PULSES_PER_HOP, 13'h1FFF);
      repeat (2) offer_sample(pick_sample(), pick_sample(), pick_step());
      wait_drained();
      write_register(REG_PULSE_LENGTH, 13'd1);
      write_register(REG_PULSES_PER_HOP, 13'd1);
      write_register(REG_SPARE_LOW, 13'h1ABC);
      write_register(REG_SPARE_HIGH, 13'h0000);
      offer_sample(pick_sample(), pick_sample(), pick_step());
      settings_used += 5;

      // random phases, each under a fresh setting and idling mix
      while (random_sent < RANDOM_ITEMS) begin
         wait_drained();
         program_random_setting(item_count);
         tx_gaps_on = ($urandom_range(0, 3) != 0);
         rx_gaps_on = ($urandom_range(0, 3) != 0);
         repeat (item_count) offer_sample(pick_sample(), pick_sample(), pick_step());
         random_sent += item_count;
      end

      // let the pipeline settle, then report
      wait_drained();
      repeat (PIPE_LATENCY * 4) @(negedge clock);
      $display("mixed %0d samples under %0d register settings in %0d cycles",
               requests_accepted, settings_used, cycle_count);
      $display("covered rails, zero and over-range registers, group shrink and long stalls");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, pending_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
